// ===== rtl/rrde_pkg.sv =====
package rrde_pkg;

    localparam int NumCoef = 6;
    localparam int QuoBits = 21;
    localparam int RemBits = 81;
    localparam int DenBits = 64;

    localparam logic [2:0] CFG_NUM_R2 = 3'd0;
    localparam logic [2:0] CFG_NUM_R4 = 3'd1;
    localparam logic [2:0] CFG_NUM_R6 = 3'd2;
    localparam logic [2:0] CFG_DEN_R2 = 3'd3;
    localparam logic [2:0] CFG_DEN_R4 = 3'd4;
    localparam logic [2:0] CFG_DEN_R6 = 3'd5;

    localparam logic [17:0] RADIUS_MAX = 18'd131072;
    localparam logic signed [18:0] OUT_MAX = 19'sd262143;
    localparam logic signed [18:0] OUT_MIN = -19'sd262144;

    typedef logic signed [31:0] t_coef [NumCoef];

    typedef struct packed {
        logic signed [18:0] tgt;
        logic               flag;
        logic               neg;
        logic               dz;
        logic               npos;
        logic               nneg;
        logic               radnz;
    } t_side;

    typedef struct packed {
        logic [RemBits-1:0] rem;
        logic [DenBits-1:0] den;
        logic [QuoBits-1:0] quo;
        t_side              side;
    } t_div;

endpackage

// ===== rtl/rrde_front.sv =====
module rrde_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rrde_pkg::t_coef      i_coef,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [17:0]          i_radius_in,
    input  logic signed [18:0]   i_target_radius,
    output logic                 o_valid,
    input  logic                 i_down_en,
    output rrde_pkg::t_div       o_data
);

    logic [8:1] r_v;
    logic [8:1] en;

    rrde_pkg::t_side r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8;
    logic [17:0] r_rad1, r_rad2, r_rad3, r_rad4, r_rad5, r_rad6;
    logic [26:0] r_pw2_1, r_pw2_2, r_pw2_3;
    logic [28:0] r_pw4_2, r_pw4_3;
    logic [30:0] r_pw6_3;
    logic signed [63:0] r_p [rrde_pkg::NumCoef];
    logic signed [65:0] r_num, r_den;
    logic [63:0] r_mn, r_md6, r_md7, r_md8;
    logic [49:0] r_lo, r_hi;
    logic [80:0] r_prod;

    logic [17:0] n_rad;
    logic [35:0] n_sq;
    logic [53:0] n_sq4;
    logic [55:0] n_sq6;
    logic signed [65:0] n_num, n_den;
    logic [81:0] n_prod;
    rrde_pkg::t_side n_s1, n_s6;

    always_comb begin
        en[8] = !r_v[8] || i_down_en;
        for (int k = 7; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[1];
    assign o_valid = r_v[8];

    always_comb begin
        n_rad = (i_radius_in > rrde_pkg::RADIUS_MAX) ? rrde_pkg::RADIUS_MAX : i_radius_in;
        n_sq  = n_rad * n_rad;
        n_s1       = '0;
        n_s1.tgt   = i_target_radius;
        n_s1.flag  = (i_radius_in > rrde_pkg::RADIUS_MAX);
        n_s1.radnz = (n_rad != 18'd0);
    end

    assign n_sq4 = r_pw2_1 * r_pw2_1 + 54'd8388608;
    assign n_sq6 = r_pw4_2 * r_pw2_2 + 56'd8388608;

    always_comb begin
        n_num = (66'sd1 <<< 48) + {{2{r_p[0][63]}}, r_p[0]} + {{2{r_p[1][63]}}, r_p[1]}
                + {{2{r_p[2][63]}}, r_p[2]};
        n_den = (66'sd1 <<< 48) + {{2{r_p[3][63]}}, r_p[3]} + {{2{r_p[4][63]}}, r_p[4]}
                + {{2{r_p[5][63]}}, r_p[5]};
    end

    always_comb begin
        n_s6      = r_s5;
        n_s6.neg  = r_num[65] ^ r_den[65];
        n_s6.dz   = (r_den == 66'sd0);
        n_s6.npos = !r_num[65] && (r_num != 66'sd0);
        n_s6.nneg = r_num[65];
    end

    assign n_prod = {32'b0, r_lo} + {r_hi, 32'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_valid;
            for (int k = 2; k <= 8; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1    <= n_s1;
            r_rad1  <= n_rad;
            r_pw2_1 <= 27'((n_sq + 36'd128) >> 8);
        end
        if (en[2]) begin
            r_s2    <= r_s1;
            r_rad2  <= r_rad1;
            r_pw2_2 <= r_pw2_1;
            r_pw4_2 <= 29'(n_sq4 >> 24);
        end
        if (en[3]) begin
            r_s3    <= r_s2;
            r_rad3  <= r_rad2;
            r_pw2_3 <= r_pw2_2;
            r_pw4_3 <= r_pw4_2;
            r_pw6_3 <= 31'(n_sq6 >> 24);
        end
        if (en[4]) begin
            r_s4   <= r_s3;
            r_rad4 <= r_rad3;
            r_p[0] <= i_coef[0] * $signed({37'b0, r_pw2_3});
            r_p[1] <= i_coef[1] * $signed({35'b0, r_pw4_3});
            r_p[2] <= i_coef[2] * $signed({33'b0, r_pw6_3});
            r_p[3] <= i_coef[3] * $signed({37'b0, r_pw2_3});
            r_p[4] <= i_coef[4] * $signed({35'b0, r_pw4_3});
            r_p[5] <= i_coef[5] * $signed({33'b0, r_pw6_3});
        end
        if (en[5]) begin
            r_s5   <= r_s4;
            r_rad5 <= r_rad4;
            r_num  <= n_num;
            r_den  <= n_den;
        end
        if (en[6]) begin
            r_s6   <= n_s6;
            r_rad6 <= r_rad5;
            r_mn   <= r_num[65] ? 64'(-r_num) : r_num[63:0];
            r_md6  <= r_den[65] ? 64'(-r_den) : r_den[63:0];
        end
        if (en[7]) begin
            r_s7  <= r_s6;
            r_md7 <= r_md6;
            r_lo  <= r_rad6 * r_mn[31:0];
            r_hi  <= r_rad6 * r_mn[63:32];
        end
        if (en[8]) begin
            r_s8   <= r_s7;
            r_md8  <= r_md7;
            r_prod <= n_prod[80:0];
        end
    end

    always_comb begin
        o_data      = '0;
        o_data.rem  = r_prod;
        o_data.den  = r_md8;
        o_data.side = r_s8;
    end

endmodule

// ===== rtl/rrde_div_cell.sv =====
module rrde_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [4:0]     i_bit_idx,
    input  logic           i_valid,
    input  rrde_pkg::t_div i_data,
    output logic           o_en,
    input  logic           i_down_en,
    output logic           o_valid,
    output rrde_pkg::t_div o_data
);

    logic           r_v;
    rrde_pkg::t_div r_d;
    rrde_pkg::t_div n_d;
    logic [84:0]    trial;

    assign o_en    = !r_v || i_down_en;
    assign o_valid = r_v;
    assign o_data  = r_d;

    // one quotient bit: subtract the shifted divisor when it fits
    always_comb begin
        trial = {4'b0, i_data.rem} - ({21'b0, i_data.den} << i_bit_idx);
        n_d   = i_data;
        if (!trial[84]) begin
            n_d.rem = trial[80:0];
            n_d.quo = i_data.quo | (21'b1 << i_bit_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_d <= n_d;
        end
    end

endmodule

// ===== rtl/rational_radial_distortion_even_unit.sv =====
// Channel   Handshake            Payload
// input     i_valid / o_ready    i_radius_in, i_target_radius
// output    o_valid / i_ready    o_model_radius, o_residual, o_range_error
// config    i_cfg_we             i_cfg_idx, i_cfg_data
// One word per cycle sustained while the output is not stalled.
// The pipeline runs 8 stages of powers, products and sums into the 21-cell restoring
// divider (one quotient bit per cell), then 2 output stages.
// Synchronous active-low reset clears valids and coefficients.
// Stalls ripple back stage by stage, so bubbles are squeezed out.
module rational_radial_distortion_even_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [17:0]        i_radius_in,
    input  logic signed [18:0] i_target_radius,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [18:0] o_model_radius,
    output logic signed [18:0] o_residual,
    output logic               o_range_error
);

    rrde_pkg::t_coef r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rrde_pkg::NumCoef; k++) r_coef[k] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rrde_pkg::CFG_NUM_R2: r_coef[0] <= i_cfg_data;
                rrde_pkg::CFG_NUM_R4: r_coef[1] <= i_cfg_data;
                rrde_pkg::CFG_NUM_R6: r_coef[2] <= i_cfg_data;
                rrde_pkg::CFG_DEN_R2: r_coef[3] <= i_cfg_data;
                rrde_pkg::CFG_DEN_R4: r_coef[4] <= i_cfg_data;
                rrde_pkg::CFG_DEN_R6: r_coef[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    localparam int NumCells = rrde_pkg::QuoBits;

    rrde_pkg::t_div w_d  [NumCells+1];
    logic           w_v  [NumCells+1];
    logic           w_en [NumCells+1];

    rrde_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_coef         (r_coef),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_radius_in    (i_radius_in),
        .i_target_radius(i_target_radius),
        .o_valid        (w_v[0]),
        .i_down_en      (w_en[0]),
        .o_data         (w_d[0])
    );

    for (genvar k = 0; k < NumCells; k++) begin : g_cell
        rrde_div_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_bit_idx(5'(NumCells - 1 - k)),
            .i_valid  (w_v[k]),
            .i_data   (w_d[k]),
            .o_en     (w_en[k]),
            .i_down_en(w_en[k+1]),
            .o_valid  (w_v[k+1]),
            .o_data   (w_d[k+1])
        );
    end

    // round, saturate and fix the sign
    logic               r_a_v, r_o_v;
    logic               en_a, en_o;
    logic signed [18:0] r_a_model, r_a_tgt;
    logic               r_a_flag;
    rrde_pkg::t_div     dq;
    logic               rnd;
    logic [20:0]        mag;
    logic signed [18:0] n_model;
    logic               n_flag;

    assign dq   = w_d[NumCells];
    assign en_o = !r_o_v || i_ready;
    assign en_a = !r_a_v || en_o;
    assign w_en[NumCells] = en_a;

    always_comb begin
        rnd     = ({dq.rem[63:0], 1'b0} >= {1'b0, dq.den});
        mag     = dq.quo[20] ? 21'h100000 : ({1'b0, dq.quo[19:0]} + 21'(rnd));
        n_flag  = dq.side.flag;
        n_model = '0;
        if (dq.side.dz) begin
            n_flag = 1'b1;
            if (dq.side.npos && dq.side.radnz) n_model = rrde_pkg::OUT_MAX;
            else if (dq.side.nneg && dq.side.radnz) n_model = rrde_pkg::OUT_MIN;
        end else if (!dq.side.neg) begin
            if (mag > 21'd262143) begin
                n_model = rrde_pkg::OUT_MAX;
                n_flag  = 1'b1;
            end else begin
                n_model = $signed(mag[18:0]);
            end
        end else begin
            if (mag > 21'd262144) begin
                n_model = rrde_pkg::OUT_MIN;
                n_flag  = 1'b1;
            end else begin
                n_model = $signed(19'(-mag));
            end
        end
    end

    logic signed [19:0] diff;
    logic signed [18:0] n_res;
    logic               n_rflag;

    always_comb begin
        diff    = {r_a_tgt[18], r_a_tgt} - {r_a_model[18], r_a_model};
        n_res   = diff[18:0];
        n_rflag = r_a_flag;
        if (diff > 20'sd262143) begin
            n_res   = rrde_pkg::OUT_MAX;
            n_rflag = 1'b1;
        end else if (diff < -20'sd262144) begin
            n_res   = rrde_pkg::OUT_MIN;
            n_rflag = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (en_a) r_a_v <= w_v[NumCells];
            if (en_o) r_o_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_model <= n_model;
            r_a_tgt   <= dq.side.tgt;
            r_a_flag  <= n_flag;
        end
        if (en_o) begin
            o_model_radius <= r_a_model;
            o_residual     <= n_res;
            o_range_error  <= n_rflag;
        end
    end

    assign o_valid = r_o_v;

endmodule

// ===== dv/rrde_checker.sv =====
module rrde_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic               i_in_ready,
    input  logic [17:0]        i_radius_in,
    input  logic signed [18:0] i_target_radius,
    input  logic               i_out_valid,
    input  logic               i_ready,
    input  logic signed [18:0] i_model_radius,
    input  logic signed [18:0] i_residual,
    input  logic               i_range_error,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [18:0] model;
        logic signed [18:0] res;
        logic               flag;
    } t_lens_out;

    logic signed [31:0] lens_coef [rrde_pkg::NumCoef];
    t_lens_out          lens_expected [$];

    // Exact r*N/D with round half away, capped at 2^20 like the block.
    function automatic logic [20:0] rounded_ratio(logic [17:0] rad,
                                                  logic [63:0] mag_n,
                                                  logic [63:0] mag_d);
        logic [127:0] prod;
        logic [127:0] q;
        logic [127:0] r;
        prod = 128'(rad) * 128'(mag_n);
        q = prod / 128'(mag_d);
        r = prod % 128'(mag_d);
        if (r >= 128'(mag_d) - r) q = q + 1;
        if (q > 128'(1 << 20)) q = 128'(1 << 20);
        return q[20:0];
    endfunction

    function automatic t_lens_out predict_lens(logic [17:0] rad_in,
                                               logic signed [18:0] tgt);
        t_lens_out   o;
        logic [17:0] rad;
        logic [63:0] p2, p4, p6;
        logic signed [63:0] num, den, model, diff;
        logic [63:0] mn, md;
        logic [20:0] q;
        o.flag = 1'b0;
        rad = rad_in;
        if (rad > rrde_pkg::RADIUS_MAX) begin
            rad = rrde_pkg::RADIUS_MAX;
            o.flag = 1'b1;
        end
        p2 = (64'(rad) * 64'(rad) + 128) >> 8;
        p4 = (p2 * p2 + (64'd1 << 23)) >> 24;
        p6 = (p4 * p2 + (64'd1 << 23)) >> 24;
        num = (64'sd1 <<< 48) + 64'(lens_coef[rrde_pkg::CFG_NUM_R2]) * $signed(p2)
            + 64'(lens_coef[rrde_pkg::CFG_NUM_R4]) * $signed(p4)
            + 64'(lens_coef[rrde_pkg::CFG_NUM_R6]) * $signed(p6);
        den = (64'sd1 <<< 48) + 64'(lens_coef[rrde_pkg::CFG_DEN_R2]) * $signed(p2)
            + 64'(lens_coef[rrde_pkg::CFG_DEN_R4]) * $signed(p4)
            + 64'(lens_coef[rrde_pkg::CFG_DEN_R6]) * $signed(p6);
        if (den == 0) begin
            o.flag = 1'b1;
            if (num > 0 && rad != 0) model = 64'(rrde_pkg::OUT_MAX);
            else if (num < 0 && rad != 0) model = 64'(rrde_pkg::OUT_MIN);
            else model = 0;
        end else begin
            mn = num < 0 ? -num : num;
            md = den < 0 ? -den : den;
            q = rounded_ratio(rad, mn, md);
            model = ((num < 0) != (den < 0)) ? -64'(q) : 64'(q);
            if (model > 64'(rrde_pkg::OUT_MAX)) begin
                model = 64'(rrde_pkg::OUT_MAX);
                o.flag = 1'b1;
            end else if (model < 64'(rrde_pkg::OUT_MIN)) begin
                model = 64'(rrde_pkg::OUT_MIN);
                o.flag = 1'b1;
            end
        end
        diff = 64'(tgt) - model;
        if (diff > 64'(rrde_pkg::OUT_MAX)) begin
            diff = 64'(rrde_pkg::OUT_MAX);
            o.flag = 1'b1;
        end else if (diff < 64'(rrde_pkg::OUT_MIN)) begin
            diff = 64'(rrde_pkg::OUT_MIN);
            o.flag = 1'b1;
        end
        o.model = model[18:0];
        o.res = diff[18:0];
        return o;
    endfunction

    assign o_pending = lens_expected.size();

    always @(posedge i_clk) begin
        t_lens_out want;
        if (!i_rst_n) begin
            foreach (lens_coef[k]) lens_coef[k] <= '0;
            lens_expected.delete();
            o_errors <= 0;
            o_flagged <= 0;
        end else begin
            if (i_cfg_we && i_cfg_idx < 3'(rrde_pkg::NumCoef))
                lens_coef[i_cfg_idx] <= i_cfg_data;
            if (i_valid && i_in_ready)
                lens_expected = {lens_expected, predict_lens(i_radius_in, i_target_radius)};
            if (i_out_valid && i_ready) begin
                if (lens_expected.size() == 0) begin
                    $display("%0t: unexpected word model=%0d res=%0d flag=%0b", $time,
                             i_model_radius, i_residual, i_range_error);
                    o_errors <= o_errors + 1;
                end else begin
                    want = lens_expected.pop_front();
                    if (want.flag) o_flagged <= o_flagged + 1;
                    if (want.model !== i_model_radius || want.res !== i_residual
                        || want.flag !== i_range_error) begin
                        $display("%0t: mismatch expected model=%0d res=%0d flag=%0b, got %0d %0d %0b",
                                 $time, want.model, want.res, want.flag,
                                 i_model_radius, i_residual, i_range_error);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/tb_rational_radial_distortion_even_unit.sv =====
module tb_rational_radial_distortion_even_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 5000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [17:0]        i_radius_in = '0;
    logic signed [18:0] i_target_radius = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [18:0] o_model_radius;
    logic signed [18:0] o_residual;
    logic               o_range_error;
    int                 errors, pending, flagged;
    int                 sink_idle_pct = 0;
    bit                 sink_hold = 1'b0;
    int                 words_sent = 0;
    int                 idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rational_radial_distortion_even_unit u_dut (.*);

    rrde_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_valid,
        .i_in_ready(o_ready), .i_radius_in, .i_target_radius,
        .i_out_valid(o_valid), .i_ready, .i_model_radius(o_model_radius),
        .i_residual(o_residual), .i_range_error(o_range_error),
        .o_errors(errors), .o_pending(pending), .o_flagged(flagged)
    );

    always @(negedge i_clk) begin
        i_ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog: count cycles with no accepted word on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("tb_rational_radial_distortion_even_unit: errors");
                $finish;
            end
        end
    end

    // Leave valid high after the accept; the next word or drain() decides.
    task automatic send_word(logic [17:0] rad, logic signed [18:0] tgt, int gap_pct);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_radius_in <= rad;
        i_target_radius <= tgt;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_coef(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_coefs(logic [31:0] a1, a2, a3, b1, b2, b3);
        write_coef(rrde_pkg::CFG_NUM_R2, a1);
        write_coef(rrde_pkg::CFG_NUM_R4, a2);
        write_coef(rrde_pkg::CFG_NUM_R6, a3);
        write_coef(rrde_pkg::CFG_DEN_R2, b1);
        write_coef(rrde_pkg::CFG_DEN_R4, b2);
        write_coef(rrde_pkg::CFG_DEN_R6, b3);
    endtask

    function automatic logic [17:0] pick_radius();
        case ($urandom_range(9))
            0: return 18'($urandom_range(262143));
            1: return rrde_pkg::RADIUS_MAX;
            2: return 18'($urandom_range(15));
            default: return 18'($urandom_range(131072));
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            3: return '0;
            default: return 32'($signed($urandom_range(2 << 24)) - (1 << 24));
        endcase
    endfunction

    task automatic random_phase(int count, int gap_pct);
        repeat (count) send_word(pick_radius(), 19'($urandom()), gap_pct);
    endtask

    initial begin
        logic [17:0] rad_dir [8] = '{18'd0, 18'd1, 18'd65536, 18'd131071,
                                     18'd131072, 18'd131073, 18'h3ffff, 18'd100000};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Identity model at reset values, then target extremes.
        foreach (rad_dir[k]) send_word(rad_dir[k], rrde_pkg::OUT_MAX, 0);
        send_word(18'd131072, rrde_pkg::OUT_MIN, 0);
        send_word(18'd0, rrde_pkg::OUT_MIN, 0);
        drain();
        // Denominator zero at r=1: b1 = -1.0; numerator positive, negative, zero.
        load_coefs(32'h0100_0000, 0, 0, 32'hff00_0000, 0, 0);
        send_word(18'd65536, 19'sd5, 0);
        send_word(18'd0, 19'sd5, 0);
        drain();
        write_coef(rrde_pkg::CFG_NUM_R2, 32'hfe00_0000);
        send_word(18'd65536, -19'sd5, 0);
        drain();
        write_coef(rrde_pkg::CFG_NUM_R2, 32'hff00_0000);
        send_word(18'd65536, 19'sd0, 0);
        drain();
        // Huge gain saturates model; bad register index is ignored.
        load_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0);
        write_coef(3'd6, 32'h1234_5678);
        write_coef(3'd7, 32'hffff_ffff);
        send_word(18'd131072, rrde_pkg::OUT_MIN, 0);
        send_word(18'd40000, rrde_pkg::OUT_MAX, 0);
        drain();
        load_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(18'd131072, rrde_pkg::OUT_MAX, 0);
        send_word(18'd70000, -19'sd1, 0);
        drain();

        // Random phases with differing coefficients and idling.
        sink_idle_pct = 51;
        for (int ph = 0; ph < 3; ph++) begin
            load_coefs(pick_coef(), pick_coef(), pick_coef(),
                       pick_coef(), pick_coef(), pick_coef());
            random_phase(105, 30);
            drain();
        end
        sink_idle_pct = 30;
        for (int ph = 0; ph < 3; ph++) begin
            load_coefs(pick_coef(), pick_coef(), pick_coef(),
                       pick_coef(), pick_coef(), pick_coef());
            random_phase(105, 51);
            drain();
        end
        sink_idle_pct = 0;
        load_coefs(32'h0010_0000, 32'hfff8_0000, 32'h0001_0000,
                   32'h0020_0000, 32'h0004_0000, 32'hfffe_0000);
        random_phase(150, 0);

        // Hold the output off long enough that the pipeline fills and stalls input.
        fork
            begin
                sink_hold = 1'b1;
                repeat (120) @(negedge i_clk);
                sink_hold = 1'b0;
            end
            random_phase(80, 0);
        join
        drain();
        load_coefs('0, '0, '0, '0, '0, '0);
        random_phase(60, 10);
        drain();

        $display("Sent %0d words over several coefficient sets; %0d results carried range_error.",
                 words_sent, flagged);
        if (errors == 0) begin
            $display("tb_rational_radial_distortion_even_unit: clean");
        end else begin
            $display("tb_rational_radial_distortion_even_unit: errors");
        end
        $finish;
    end
endmodule
